### hdl/pcts_pkg.sv
// Shared constants and types for the priority counter task scheduler.
package pcts_pkg;

  localparam int NUM_TASKS = 8;
  localparam int TIDX_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int TASK_W    = 3;
  localparam int PRIO_W    = 8;
  localparam int PRIOS_W   = 56;
  localparam int SLICE_W   = 9;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 64;

  // Byte address bit that separates the priority register from unused space.
  localparam int REG_SEL_BIT = 3;

  localparam logic [PRIOS_W-1:0] PRIO_RESET = 56'h01010101010101;

  typedef struct packed {
    logic               no_task_ready;
    logic [SLICE_W-1:0] slice_left;
    logic               slices_reloaded;
    logic               task_switched;
    logic [TASK_W-1:0]  running_task;
  } sched_res_t;

endpackage

### hdl/priority_counter_task_scheduler.sv
// Top level of the priority counter task scheduler: stream ports, register port, result register.
//
// Each input transfer carries one timer tick flag and yields exactly one result transfer.
// A status item (tick 0) goes straight to the result. A tick from a running task first
// decrements that task's slice counter and keeps the task while the counter stays above
// zero; otherwise, and on every tick from the idle task, the sequencer scans the tasks
// from the highest down for the largest counter. When every slice counter is empty the
// counters are refilled and scanned again. The sequencer steps the one comparator and
// the one counter read port through the tasks, one task per cycle. The input side is
// ready only while the sequencer is idle; a finished result waits in the output
// register, and the sequencer holds its last step until that register is free. Task
// priorities sit in one 56-bit register at address 0.
module priority_counter_task_scheduler (
  input  logic                         clk,
  input  logic                         rst,
  // Input stream.
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,  // [0] timer_tick
  // Result stream.
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [2:0] running_task, [3] task_switched, [4] slices_reloaded,
  // [13:5] slice_left, [14] no_task_ready
  output logic [15:0]                  m_tdata,
  // Register port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pcts_pkg::APB_AW-1:0]  paddr,
  input  logic [pcts_pkg::APB_DW-1:0]  pwdata,
  output logic [pcts_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  logic [pcts_pkg::PRIOS_W-1:0] prios;
  logic                         core_idle;
  logic                         res_valid;
  logic                         res_ready;
  pcts_pkg::sched_res_t         res;
  logic                         reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = !paddr[pcts_pkg::REG_SEL_BIT];
  assign prdata  = reg_hit ? pcts_pkg::APB_DW'(prios) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      prios <= pcts_pkg::PRIO_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      prios <= pwdata[pcts_pkg::PRIOS_W-1:0];
    end
  end

  assign s_tready  = core_idle;
  assign res_ready = !m_tvalid || m_tready;

  pcts_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (s_tvalid && s_tready),
    .tick      (s_tdata[0]),
    .prios     (prios),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {1'b0, res.no_task_ready, res.slice_left, res.slices_reloaded,
                  res.task_switched, res.running_task};
    end
  end

endmodule

### hdl/pcts_core.sv
// Scheduling sequencer with the per-task slice counters and one shared compare unit.
module pcts_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            tick,
  input  logic [pcts_pkg::PRIOS_W-1:0]    prios,
  output logic                            idle,
  output logic                            res_valid,
  input  logic                            res_ready,
  output pcts_pkg::sched_res_t            res
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DEC    = 5'b00010,
    S_SCAN   = 5'b00100,
    S_RELOAD = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  localparam logic [pcts_pkg::TIDX_W-1:0] LAST_IDX = pcts_pkg::TIDX_W'(pcts_pkg::NUM_TASKS - 1);
  localparam logic [pcts_pkg::TIDX_W-1:0] FIRST_IDX = pcts_pkg::TIDX_W'(1);

  state_t                          state;
  logic [pcts_pkg::TIDX_W-1:0]     idx;
  logic [pcts_pkg::TASK_W-1:0]     cur;
  logic [pcts_pkg::TASK_W-1:0]     nxt;
  logic [pcts_pkg::SLICE_W-1:0]    bestc;
  logic                            tick_q;
  logic                            reloaded;
  logic                            none;
  // Entry 0 belongs to the idle task; only reset writes it, and it always reads zero.
  logic [pcts_pkg::SLICE_W-1:0]    cnt [pcts_pkg::NUM_TASKS];
  logic [pcts_pkg::PRIO_W-1:0]     prio_arr [pcts_pkg::NUM_TASKS];

  logic [pcts_pkg::SLICE_W-1:0]    rd;
  logic [pcts_pkg::SLICE_W-1:0]    dec;
  logic [pcts_pkg::SLICE_W-1:0]    refill;
  logic                            take;
  logic [pcts_pkg::TASK_W-1:0]     best_n;

  for (genvar k = 0; k < pcts_pkg::NUM_TASKS; k++) begin : g_prio
    if (k == 0) begin : g_idle
      assign prio_arr[k] = '0;
    end else begin : g_task
      assign prio_arr[k] = prios[pcts_pkg::PRIO_W*(k-1) +: pcts_pkg::PRIO_W];
    end
  end

  assign rd     = cnt[idx];
  assign dec    = (rd == '0) ? '0 : rd - pcts_pkg::SLICE_W'(1);
  assign refill = {1'b0, rd[pcts_pkg::SLICE_W-1:1]} + pcts_pkg::SLICE_W'(prio_arr[idx]);
  // Strictly greater while scanning downward, so ties keep the higher task.
  assign take   = rd > bestc;
  assign best_n = take ? pcts_pkg::TASK_W'(idx) : nxt;

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_FIN);

  always_comb begin
    res.running_task    = nxt;
    res.task_switched   = tick_q && (nxt != cur);
    res.slices_reloaded = reloaded;
    res.slice_left      = rd;
    res.no_task_ready   = none;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      cur      <= '0;
      nxt      <= '0;
      bestc    <= '0;
      tick_q   <= 1'b0;
      reloaded <= 1'b0;
      none     <= 1'b0;
      for (int k = 0; k < pcts_pkg::NUM_TASKS; k++) begin
        cnt[k] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            tick_q   <= tick;
            reloaded <= 1'b0;
            none     <= 1'b0;
            bestc    <= '0;
            if (!tick) begin
              nxt   <= cur;
              idx   <= pcts_pkg::TIDX_W'(cur);
              state <= S_FIN;
            end else if (cur == '0) begin
              nxt   <= '0;
              idx   <= LAST_IDX;
              state <= S_SCAN;
            end else begin
              nxt   <= cur;
              idx   <= pcts_pkg::TIDX_W'(cur);
              state <= S_DEC;
            end
          end
        end
        S_DEC: begin
          cnt[idx] <= dec;
          if (dec == '0) begin
            nxt   <= '0;
            bestc <= '0;
            idx   <= LAST_IDX;
            state <= S_SCAN;
          end else begin
            state <= S_FIN;
          end
        end
        S_SCAN: begin
          if (take) begin
            bestc <= rd;
            nxt   <= pcts_pkg::TASK_W'(idx);
          end
          if (idx == FIRST_IDX) begin
            if (best_n != '0) begin
              idx   <= pcts_pkg::TIDX_W'(best_n);
              state <= S_FIN;
            end else if (!reloaded) begin
              idx   <= FIRST_IDX;
              state <= S_RELOAD;
            end else begin
              // Every priority is zero: fall back to the idle task.
              none  <= 1'b1;
              idx   <= '0;
              state <= S_FIN;
            end
          end else begin
            idx <= idx - pcts_pkg::TIDX_W'(1);
          end
        end
        S_RELOAD: begin
          cnt[idx] <= refill;
          reloaded <= 1'b1;
          if (idx == LAST_IDX) begin
            nxt   <= '0;
            bestc <= '0;
            state <= S_SCAN;
          end else begin
            idx <= idx + pcts_pkg::TIDX_W'(1);
          end
        end
        S_FIN: begin
          if (res_ready) begin
            cur   <= nxt;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
